FILE: rtl/core/fct_pkg.sv
// Shared types and constants for the chain table engine.
// Depends on nothing; imported by every module of the block.
package fct_pkg;

    localparam int TableEntries = 8192;
    localparam int IdxW  = $clog2(TableEntries);
    localparam int LinkW = 16;
    localparam int HopW  = 14;
    localparam int TotW  = 14;
    localparam int DbcW  = 14;
    localparam int CntW  = ($clog2(TableEntries + 1) > HopW) ? $clog2(TableEntries + 1) : HopW;

    localparam logic [LinkW-1:0] EndMark  = 16'hFFFF;
    localparam logic [DbcW-1:0]  DbcReset = 14'd8192;

    typedef enum logic [2:0] {
        ACT_LOAD   = 3'd0,
        ACT_PEEK   = 3'd1,
        ACT_WALK   = 3'd2,
        ACT_FREE   = 3'd3,
        ACT_EXTEND = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_NOSPACE = 2'd2
    } t_status;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_PEEK = 11'b000_0000_0010,
        S_WCHK = 11'b000_0000_0100,
        S_WNXT = 11'b000_0000_1000,
        S_FCHK = 11'b000_0001_0000,
        S_FWR  = 11'b000_0010_0000,
        S_TCHK = 11'b000_0100_0000,
        S_TNXT = 11'b000_1000_0000,
        S_SCHK = 11'b001_0000_0000,
        S_SEV  = 11'b010_0000_0000,
        S_SLNK = 11'b100_0000_0000
    } t_state;

    function automatic logic in_table(input logic [LinkW-1:0] idx);
        return idx < LinkW'(TableEntries);
    endfunction

endpackage

FILE: rtl/core/fat_chain_table_engine.sv
// Top level of the chain table engine: request decode, sequencer, result register.
// Depends on fct_pkg and fct_link_ram.
//
// File allocation table engine. The table holds 8192 links of 16 bits (0 = free,
// 0xFFFF = end of chain) in one synchronous RAM with a registered read; its content
// is undefined after reset and must be loaded with load requests before any entry
// is read, so there is no clearing pass and the block is ready right out of reset.
// A request is taken when start is high and busy is low. Every request gives
// exactly one result, shown for one cycle with o_done; the receiver cannot stall
// it, so capture it on that cycle. Each entry looked at takes a read of the single
// RAM read port and a check of the data read back:
//   load, out-of-range peek, unknown action: result in the cycle after the request;
//   peek: one read of the entry; walk: one read per hop; free: one read and
//   one clearing write per entry; extend: one read per entry of the existing
//   chain and per entry scanned, plus one write for each block found free and
//   a second write for each block linked behind an existing tail.
// A new request may be given in the cycle o_done is high. data_block_count is
// written by the user through i_cfg_we / i_cfg_wdata only while the block is idle,
// which the block does not enforce; it bounds the ascending free-block scan of extend (resets to 8192).
module fat_chain_table_engine import fct_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       i_action,
    input  logic [LinkW-1:0] i_start_index,
    input  logic [HopW-1:0]  i_hop_count,
    input  logic [LinkW-1:0] i_entry_value,
    input  logic             i_cfg_we,
    input  logic [DbcW-1:0]  i_cfg_wdata,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [LinkW-1:0] o_block_index,
    output logic [TotW-1:0]  o_block_total
);

    // control state
    t_state           r_state, n_state;
    logic             r_done,  n_done;
    logic [DbcW-1:0]  r_dbc;

    // working registers
    logic [LinkW-1:0] r_cur,  n_cur;    // walk/free position
    logic [LinkW-1:0] r_head, n_head;   // extend: chain head
    logic [LinkW-1:0] r_tail, n_tail;   // extend: current tail
    logic [IdxW-1:0]  r_prev, n_prev;   // extend: tail to relink
    logic [CntW-1:0]  r_cnt,  n_cnt;    // hops / entries freed / chain entries walked, then blocks appended
    logic [CntW-1:0]  r_scan, n_scan;   // extend: free-scan position
    logic [HopW-1:0]  r_hops, n_hops;

    // result register
    t_status          r_status, n_status;
    logic [LinkW-1:0] r_bidx,   n_bidx;
    logic [TotW-1:0]  r_btot,   n_btot;

    // RAM port
    logic             ram_we;
    logic [IdxW-1:0]  ram_waddr;
    logic [LinkW-1:0] ram_wdata;
    logic [IdxW-1:0]  ram_raddr;
    logic [LinkW-1:0] ram_rdata;

    logic [CntW-1:0]  scan_limit;

    fct_link_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // scan covers entries 0 .. min(data_block_count, table size) - 1
    assign scan_limit = (CntW'(r_dbc) < CntW'(TableEntries)) ? CntW'(r_dbc)
                                                             : CntW'(TableEntries);

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_cur    = r_cur;
        n_head   = r_head;
        n_tail   = r_tail;
        n_prev   = r_prev;
        n_cnt    = r_cnt;
        n_scan   = r_scan;
        n_hops   = r_hops;
        n_status = r_status;
        n_bidx   = r_bidx;
        n_btot   = r_btot;
        ram_we    = 1'b0;
        ram_waddr = r_cur[IdxW-1:0];
        ram_wdata = '0;
        ram_raddr = r_cur[IdxW-1:0];

        unique case (r_state)
            S_IDLE: begin
                ram_raddr = i_start_index[IdxW-1:0];
                if (start) begin
                    n_cur  = i_start_index;
                    n_head = i_start_index;
                    n_tail = i_start_index;
                    n_hops = i_hop_count;
                    n_cnt  = '0;
                    n_scan = '0;
                    unique case (t_action'(i_action))
                        ACT_LOAD: begin
                            n_done = 1'b1;
                            n_bidx = '0;
                            n_btot = '0;
                            if (in_table(i_start_index)) begin
                                ram_we    = 1'b1;
                                ram_waddr = i_start_index[IdxW-1:0];
                                ram_wdata = i_entry_value;
                                n_status  = ST_OK;
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        ACT_PEEK: begin
                            if (in_table(i_start_index)) begin
                                n_state = S_PEEK;
                            end else begin
                                n_done   = 1'b1;
                                n_status = ST_RANGE;
                                n_bidx   = '0;
                                n_btot   = '0;
                            end
                        end
                        ACT_WALK: n_state = S_WCHK;
                        ACT_FREE: n_state = S_FCHK;
                        ACT_EXTEND: begin
                            // empty chain goes straight to the scan
                            n_state = (i_start_index == EndMark) ? S_SCHK : S_TCHK;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = ST_RANGE;
                            n_bidx   = '0;
                            n_btot   = '0;
                        end
                    endcase
                end
            end

            S_PEEK: begin
                n_done   = 1'b1;
                n_status = ST_OK;
                n_bidx   = ram_rdata;
                n_btot   = '0;
                n_state  = S_IDLE;
            end

            S_WCHK: begin
                if (r_cnt == CntW'(r_hops)) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_bidx   = r_cur;
                    n_btot   = '0;
                    n_state  = S_IDLE;
                end else if (r_cur == EndMark || !in_table(r_cur)) begin
                    n_done   = 1'b1;
                    n_status = ST_RANGE;
                    n_bidx   = r_cur;
                    n_btot   = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_WNXT;
                end
            end

            S_WNXT: begin
                n_cur   = ram_rdata;
                n_cnt   = r_cnt + 1'b1;
                n_state = S_WCHK;
            end

            S_FCHK: begin
                if (r_cur == EndMark) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_bidx   = '0;
                    n_btot   = r_cnt[TotW-1:0];
                    n_state  = S_IDLE;
                end else if (!in_table(r_cur) || r_cnt >= CntW'(TableEntries)) begin
                    // broken chain or a loop: what was cleared stays cleared
                    n_done   = 1'b1;
                    n_status = ST_RANGE;
                    n_bidx   = '0;
                    n_btot   = r_cnt[TotW-1:0];
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_FWR;
                end
            end

            S_FWR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cur[IdxW-1:0];
                ram_wdata = '0;
                n_cur     = ram_rdata;
                n_cnt     = r_cnt + 1'b1;
                n_state   = S_FCHK;
            end

            S_TCHK: begin
                ram_raddr = r_tail[IdxW-1:0];
                if (!in_table(r_tail) || r_cnt >= CntW'(TableEntries)) begin
                    n_done   = 1'b1;
                    n_status = ST_RANGE;
                    n_bidx   = r_head;
                    n_btot   = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_TNXT;
                end
            end

            S_TNXT: begin
                if (ram_rdata == EndMark) begin
                    n_cnt   = '0;
                    n_scan  = '0;
                    n_state = S_SCHK;
                end else begin
                    n_tail  = ram_rdata;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_TCHK;
                end
            end

            S_SCHK: begin
                ram_raddr = r_scan[IdxW-1:0];
                if (r_scan < scan_limit && r_cnt < CntW'(r_hops)) begin
                    n_state = S_SEV;
                end else begin
                    n_done   = 1'b1;
                    n_status = (r_cnt < CntW'(r_hops)) ? ST_NOSPACE : ST_OK;
                    n_bidx   = r_head;
                    n_btot   = r_cnt[TotW-1:0];
                    n_state  = S_IDLE;
                end
            end

            S_SEV: begin
                if (ram_rdata == '0) begin
                    // free block: mark it as the new end; link the old tail to it or make it the head
                    ram_we    = 1'b1;
                    ram_waddr = r_scan[IdxW-1:0];
                    ram_wdata = EndMark;
                    n_prev    = r_tail[IdxW-1:0];
                    n_tail    = LinkW'(r_scan);
                    n_cnt     = r_cnt + 1'b1;
                    if (r_tail == EndMark) begin
                        n_head  = LinkW'(r_scan);
                        n_scan  = r_scan + 1'b1;
                        n_state = S_SCHK;
                    end else begin
                        n_state = S_SLNK;
                    end
                end else begin
                    n_scan  = r_scan + 1'b1;
                    n_state = S_SCHK;
                end
            end

            S_SLNK: begin
                ram_we    = 1'b1;
                ram_waddr = r_prev;
                ram_wdata = LinkW'(r_scan);
                n_scan    = r_scan + 1'b1;
                n_state   = S_SCHK;
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_dbc   <= DbcReset;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_dbc <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_prev   <= n_prev;
        r_cnt    <= n_cnt;
        r_scan   <= n_scan;
        r_hops   <= n_hops;
        r_status <= n_status;
        r_bidx   <= n_bidx;
        r_btot   <= n_btot;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_block_index = r_bidx;
    assign o_block_total = r_btot;

endmodule

FILE: rtl/core/fct_link_ram.sv
// Link table storage: one write port, one read port, registered read data.
// Depends on fct_pkg for depth and word width.
module fct_link_ram import fct_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IdxW-1:0]  i_waddr,
    input  logic [LinkW-1:0] i_wdata,
    input  logic [IdxW-1:0]  i_raddr,
    output logic [LinkW-1:0] o_rdata
);

    logic [LinkW-1:0] r_mem [TableEntries];
    logic [LinkW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/fct_checker.sv
// Port-level checks for the chain table engine, bound to the top level.
// Depends on fct_pkg for status codes.
module fct_checker import fct_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [1:0] o_status
);

    // a result only follows a request or work in progress
    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy || start))
        else $error("result without a request");

    // the result cycle is also the cycle the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while still busy");

    // an accepted request either finishes at once or holds busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("request lost");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_OK || o_status == ST_RANGE || o_status == ST_NOSPACE))
        else $error("bad status code");

endmodule

bind fat_chain_table_engine fct_checker u_fct_checker (.*);
